>>> rtl/rmm_pkg.sv
`default_nettype none

package rmm_pkg;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int REGION_W  = 2;

    // Request command codes; codes above CMD_PROBE behave as a probe
    typedef enum logic [CMD_W-1:0] {
        CMD_READ_BYTE  = 3'd0,
        CMD_WRITE_BYTE = 3'd1,
        CMD_READ_WORD  = 3'd2,
        CMD_WRITE_WORD = 3'd3,
        CMD_PROBE      = 3'd4
    } cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture the accepted request
        logic issue;       // decode one byte and access the store
        logic second;      // byte at address+1 of a word
        logic finish;      // load the response register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic word;        // request touches two bytes
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/rmm_if.sv
`default_nettype none

interface rmm_req_if;
    logic                         valid;
    logic                         ready;
    logic [rmm_pkg::CMD_W-1:0]    cmd;
    logic [rmm_pkg::ADDR_W-1:0]   bus_address;
    logic [rmm_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output cmd, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input bus_address, input write_data,
                    output ready);
endinterface

interface rmm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rmm_pkg::DATA_W-1:0]    read_data;
    logic                          mapped;
    logic [rmm_pkg::REGION_W-1:0]  region_hit;

    modport source (output valid, output read_data, output mapped, output region_hit,
                    input ready);
    modport sink   (input valid, input read_data, input mapped, input region_hit,
                    output ready);
endinterface

interface rmm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rmm_pkg::CFG_IDX_W-1:0]  index;
    logic [rmm_pkg::ADDR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rmm_ctrl.sv
`default_nettype none

module rmm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rmm_pkg::dp_cmd_t       dp_cmd,
    input  wire rmm_pkg::dp_stat_t dp_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   finish;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign finish    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    assign dp_cmd.load   = req_valid && req_ready;
    assign dp_cmd.issue  = (state_reg == S_FIRST) || (state_reg == S_SECOND);
    assign dp_cmd.second = (state_reg == S_SECOND);
    assign dp_cmd.finish = finish;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = dp_stat.word ? S_SECOND : S_DONE;
            end
            S_SECOND:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rmm_datapath.sv
`default_nettype none

module rmm_datapath #(
    parameter int REGION_BYTES = 4096,
    parameter int REGION_COUNT = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [rmm_pkg::CMD_W-1:0]        req_cmd,
    input  wire logic [rmm_pkg::ADDR_W-1:0]       req_bus_address,
    input  wire logic [rmm_pkg::DATA_W-1:0]       req_write_data,
    input  wire logic                             cfg_we,
    input  wire logic [rmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rmm_pkg::ADDR_W-1:0]       cfg_data,
    input  wire rmm_pkg::dp_cmd_t                 dp_cmd,
    output rmm_pkg::dp_stat_t                     dp_stat,
    output logic [rmm_pkg::DATA_W-1:0]            read_data,
    output logic                                  mapped,
    output logic [rmm_pkg::REGION_W-1:0]          region_hit
);

    localparam int MEM_DEPTH = REGION_COUNT * REGION_BYTES;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int AD_W      = rmm_pkg::ADDR_W;
    localparam int BW        = rmm_pkg::BYTE_W;

    // region bounds
    logic [AD_W-1:0] first_reg [REGION_COUNT];
    logic [AD_W-1:0] last_reg  [REGION_COUNT];

    // request
    logic [rmm_pkg::CMD_W-1:0]  cmd_reg;
    logic [AD_W-1:0]            addr_reg;
    logic [rmm_pkg::DATA_W-1:0] wdata_reg;

    // per-access results
    logic                          hit_reg;
    logic [rmm_pkg::REGION_W-1:0]  region_reg;
    logic                          ok_reg;
    logic [BW-1:0]                 hi_reg;
    logic [BW-1:0]                 mem_q_reg;

    // response
    logic [rmm_pkg::DATA_W-1:0]    rd_out_reg;
    logic                          mapped_out_reg;
    logic [rmm_pkg::REGION_W-1:0]  region_out_reg;

    logic [BW-1:0] mem [MEM_DEPTH];

    logic                          is_read_word;
    logic                          is_read_byte;
    logic                          is_write;
    logic                          is_word;
    logic [AD_W-1:0]               byte_addr;
    logic [BW-1:0]                 wbyte;
    logic [BW-1:0]                 lo_byte;

    logic [REGION_COUNT-1:0]       in_rng;
    logic [REGION_COUNT-1:0]       off_ok;
    logic [AW-1:0]                 idx_r [REGION_COUNT];

    logic                          dec_ok;
    logic [rmm_pkg::REGION_W-1:0]  dec_region;
    logic [AW-1:0]                 dec_idx;

    assign is_read_byte = (cmd_reg == rmm_pkg::CMD_READ_BYTE);
    assign is_read_word = (cmd_reg == rmm_pkg::CMD_READ_WORD);
    assign is_write     = (cmd_reg == rmm_pkg::CMD_WRITE_BYTE) ||
                          (cmd_reg == rmm_pkg::CMD_WRITE_WORD);
    assign is_word      = is_read_word || (cmd_reg == rmm_pkg::CMD_WRITE_WORD);
    assign dp_stat.word = is_word;

    // second byte wraps at 16 bits
    assign byte_addr = dp_cmd.second ? (addr_reg + AD_W'(1)) : addr_reg;

    always_comb
    begin
        if (is_word && !dp_cmd.second)
        begin
            wbyte = wdata_reg[rmm_pkg::DATA_W-1:BW];
        end
        else
        begin
            wbyte = wdata_reg[BW-1:0];
        end
    end

    // per-region range check, offset and store index in parallel
    for (genvar gi = 0; gi < REGION_COUNT; gi++)
    begin : g_region
        localparam int BASE = gi * REGION_BYTES;
        logic [AD_W-1:0] off;

        assign in_rng[gi] = (byte_addr >= first_reg[gi]) && (byte_addr <= last_reg[gi]);
        assign off        = byte_addr - first_reg[gi];
        assign off_ok[gi] = ({1'b0, off} < (AD_W+1)'(REGION_BYTES));
        assign idx_r[gi]  = AW'(BASE) + AW'(off);
    end

    // lowest region wins; offset past the store leaves the byte unmapped
    always_comb
    begin
        dec_ok     = 1'b0;
        dec_region = '0;
        dec_idx    = '0;
        for (int r = REGION_COUNT - 1; r >= 0; r--)
        begin
            if (in_rng[r])
            begin
                dec_ok     = off_ok[r];
                dec_region = off_ok[r] ? rmm_pkg::REGION_W'(r) : '0;
                dec_idx    = idx_r[r];
            end
        end
    end

    // bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REGION_COUNT; r++)
            begin
                first_reg[r] <= '0;
                last_reg[r]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int r = 0; r < REGION_COUNT; r++)
            begin
                if (cfg_index[rmm_pkg::CFG_IDX_W-1:1] == rmm_pkg::REGION_W'(r))
                begin
                    if (cfg_index[0])
                    begin
                        last_reg[r] <= cfg_data;
                    end
                    else
                    begin
                        first_reg[r] <= cfg_data;
                    end
                end
            end
        end
    end

    // byte store, registered read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.issue && dec_ok)
        begin
            if (is_write)
            begin
                mem[dec_idx] <= wbyte;
            end
            mem_q_reg <= mem[dec_idx];
        end
    end

    assign lo_byte = ok_reg ? mem_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= req_cmd;
            addr_reg  <= req_bus_address;
            wdata_reg <= req_write_data;
        end
        if (dp_cmd.issue)
        begin
            ok_reg <= dec_ok;
            if (!dp_cmd.second)
            begin
                hit_reg    <= dec_ok;
                region_reg <= dec_region;
            end
            else
            begin
                // first byte of the word now sits in mem_q_reg
                hi_reg <= lo_byte;
            end
        end
        if (dp_cmd.finish)
        begin
            mapped_out_reg <= hit_reg;
            region_out_reg <= region_reg;
            if (is_read_word)
            begin
                rd_out_reg <= {hi_reg, lo_byte};
            end
            else if (is_read_byte)
            begin
                rd_out_reg <= {{(rmm_pkg::DATA_W-BW){1'b0}}, lo_byte};
            end
            else
            begin
                rd_out_reg <= '0;
            end
        end
    end

    assign read_data  = rd_out_reg;
    assign mapped     = mapped_out_reg;
    assign region_hit = region_out_reg;

endmodule

`default_nettype wire

>>> rtl/region_memory_map.sv
// region_memory_map: 16-bit bus address decoder over up to four regions,
// each backed by its own REGION_BYTES-byte store.
//
// Channels: req (sink) carries cmd, bus_address and write_data; rsp
// (source) returns read_data, mapped and region_hit, one response per
// request; cfg (sink) writes the region bounds, index 2r = first and
// 2r+1 = last of region r. cfg is always ready and must only be written
// while no request is in flight.
//
// Timing: byte commands and probes pass through S_IDLE, S_FIRST and
// S_DONE, word commands also through S_SECOND, set by the single-ported
// store (one byte per cycle) and a registered read. rsp.valid rises
// when S_DONE loads the response. req.ready is high only when idle.
//
// Stall: a response waits in the output register while rsp.ready is low;
// the next request may be accepted and worked on meanwhile, and it holds
// before its own response is loaded until the earlier one is taken.
//
// Reset: clears the controller and the region bounds to zero. The store
// is not cleared; an unwritten byte reads as undefined.
`default_nettype none

module region_memory_map #(
    parameter int REGION_BYTES = 4096,
    parameter int REGION_COUNT = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmm_req_if.sink    req,
    rmm_rsp_if.source  rsp,
    rmm_cfg_if.sink    cfg
);

    rmm_pkg::dp_cmd_t  dp_cmd;
    rmm_pkg::dp_stat_t dp_stat;

    // bounds are plain registers, writable every cycle
    assign cfg.ready = 1'b1;

    rmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    rmm_datapath #(
        .REGION_BYTES (REGION_BYTES),
        .REGION_COUNT (REGION_COUNT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_cmd         (req.cmd),
        .req_bus_address (req.bus_address),
        .req_write_data  (req.write_data),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .dp_cmd          (dp_cmd),
        .dp_stat         (dp_stat),
        .read_data       (rsp.read_data),
        .mapped          (rsp.mapped),
        .region_hit      (rsp.region_hit)
    );

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W    = rmm_pkg::ADDR_W;
    localparam int DATA_W    = rmm_pkg::DATA_W;
    localparam int BYTE_W    = rmm_pkg::BYTE_W;
    localparam int CMD_W     = rmm_pkg::CMD_W;
    localparam int CFG_IDX_W = rmm_pkg::CFG_IDX_W;
    localparam int REGION_W  = rmm_pkg::REGION_W;

    // Store geometry, kept equal to the defaults of the block
    localparam int REGION_BYTES = 4096;
    localparam int REGION_COUNT = 4;
    localparam int STORE_DEPTH  = REGION_BYTES * REGION_COUNT;

    // Cycles without any handshake before the run is declared hung. The
    // longest legal quiet stretch is a sender gap or a receiver stall
    // run plus the time a response takes, so this is far beyond it.
    localparam int IDLE_LIMIT   = 2000;
    // Settling time after the last response
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;

    // Highest command code; everything above CMD_PROBE is an unused code
    localparam logic [CMD_W-1:0]  CMD_TOP  = '1;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

    // Low bit of a config index: first or last bound of a region
    localparam logic BOUND_FIRST = 1'b0;
    localparam logic BOUND_LAST  = 1'b1;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_LONG
    } stall_mode_t;

    typedef struct {
        logic [DATA_W-1:0]   read_data;
        logic                mapped;
        logic [REGION_W-1:0] region_hit;
    } map_response_t;

    logic clk;
    logic rst_n;

    rmm_req_if req_ch ();
    rmm_rsp_if rsp_ch ();
    rmm_cfg_if cfg_ch ();

    region_memory_map u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the decoder: region bounds plus the four byte stores.
    // byte_written marks store bytes that hold defined data; a read is
    // never aimed at one that does not.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] region_lo [REGION_COUNT];
    logic [ADDR_W-1:0] region_hi [REGION_COUNT];
    logic [BYTE_W-1:0] shadow_bytes [STORE_DEPTH];
    bit                byte_written [STORE_DEPTH];

    // Bounds staged for the next reconfiguration
    logic [ADDR_W-1:0] next_lo [REGION_COUNT];
    logic [ADDR_W-1:0] next_hi [REGION_COUNT];

    map_response_t pending_responses [$];

    int error_count   = 0;
    int checked_count = 0;
    int read_count;
    int write_count;
    int probe_count;
    int unmapped_count;
    int setting_count;

    int  burst_left;
    bit  sender_steady;

    // Lowest-numbered region holding addr wins; an offset past the store
    // is unmapped and lower-priority regions are not tried.
    function automatic bit locate_byte(input logic [ADDR_W-1:0] addr,
                                       output logic [REGION_W-1:0] hit,
                                       output int slot);
        int offset;
        hit  = '0;
        slot = 0;
        for (int r = 0; r < REGION_COUNT; r++)
        begin
            if (addr >= region_lo[r] && addr <= region_hi[r])
            begin
                offset = int'(addr) - int'(region_lo[r]);
                if (offset >= REGION_BYTES)
                    return 1'b0;
                hit  = r[REGION_W-1:0];
                slot = r * REGION_BYTES + offset;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] fetch_byte(input logic [ADDR_W-1:0] addr);
        logic [REGION_W-1:0] hit;
        int slot;
        if (locate_byte(addr, hit, slot))
            return shadow_bytes[slot];
        return '0;
    endfunction

    function automatic void put_byte(input logic [ADDR_W-1:0] addr,
                                     input logic [BYTE_W-1:0] value);
        logic [REGION_W-1:0] hit;
        int slot;
        if (locate_byte(addr, hit, slot))
        begin
            shadow_bytes[slot] = value;
            byte_written[slot] = 1'b1;
        end
    endfunction

    // Unmapped bytes read as zero, so only mapped unwritten bytes are off limits
    function automatic bit byte_defined(input logic [ADDR_W-1:0] addr);
        logic [REGION_W-1:0] hit;
        int slot;
        if (!locate_byte(addr, hit, slot))
            return 1'b1;
        return byte_written[slot];
    endfunction

    // Expected response of one accepted request; also updates the stores
    function automatic void predict_response(input logic [CMD_W-1:0]  cmd,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [DATA_W-1:0] data);
        map_response_t       want;
        logic [ADDR_W-1:0]   next_addr;
        int                  slot;
        next_addr      = addr + 1'b1;   // wraps at 16 bits
        want.read_data = '0;
        want.mapped    = locate_byte(addr, want.region_hit, slot);
        case (cmd)
            rmm_pkg::CMD_READ_BYTE:
            begin
                want.read_data = {8'h00, fetch_byte(addr)};
                read_count++;
            end
            rmm_pkg::CMD_WRITE_BYTE:
            begin
                put_byte(addr, data[BYTE_W-1:0]);
                write_count++;
            end
            rmm_pkg::CMD_READ_WORD:
            begin
                want.read_data = {fetch_byte(addr), fetch_byte(next_addr)};
                read_count++;
            end
            rmm_pkg::CMD_WRITE_WORD:
            begin
                put_byte(addr, data[DATA_W-1:BYTE_W]);
                put_byte(next_addr, data[BYTE_W-1:0]);
                write_count++;
            end
            default:
                probe_count++;   // probe and the unused codes
        endcase
        if (!want.mapped)
            unmapped_count++;
        pending_responses.insert(pending_responses.size(), want);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Every task starts and ends on a falling edge.
    // ------------------------------------------------------------------

    // Bursts of random length with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = sender_steady ? 0 :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_request(input logic [CMD_W-1:0]  cmd,
                                input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        req_ch.cmd         = cmd;
        req_ch.bus_address = addr;
        req_ch.write_data  = data;
        req_ch.valid       = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_response(cmd, addr, data);
        @(negedge clk);
        pace_sender();
    endtask

    // Holds the request channel quiet until every response is back
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_region_reg(input int r, input logic bound,
                                    input logic [ADDR_W-1:0] value);
        cfg_ch.index = {r[CFG_IDX_W-2:0], bound};
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        if (bound == BOUND_LAST)
            region_hi[r] = value;
        else
            region_lo[r] = value;
        @(negedge clk);
    endtask

    // Writes all eight bounds from next_lo/next_hi, only once idle
    task automatic apply_regions();
        wait_drained();
        for (int r = 0; r < REGION_COUNT; r++)
        begin
            write_region_reg(r, BOUND_FIRST, next_lo[r]);
            write_region_reg(r, BOUND_LAST, next_hi[r]);
        end
        cfg_ch.valid = 1'b0;
        setting_count++;
    endtask

    // Mostly small windows, some exactly one store long, some longer than
    // the store, some inverted; later regions sometimes overlap earlier ones.
    task automatic random_regions();
        int span;
        int pick;
        for (int r = 0; r < REGION_COUNT; r++)
        begin
            next_lo[r] = ADDR_W'($urandom);
            if (r > 0 && $urandom_range(0, 4) == 0)
                next_lo[r] = next_lo[r-1] + ADDR_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            if (pick == 9)
            begin
                next_lo[r] = ADDR_W'($urandom_range(1, ADDR_TOP));
                next_hi[r] = ADDR_W'($urandom_range(0, int'(next_lo[r]) - 1));
            end
            else
            begin
                span = (pick < 5) ? $urandom_range(1, 48) :
                       (pick < 7) ? REGION_BYTES :
                       $urandom_range(REGION_BYTES + 1, 3 * REGION_BYTES);
                if (int'(next_lo[r]) + span - 1 > int'(ADDR_TOP))
                    next_hi[r] = ADDR_TOP;
                else
                    next_hi[r] = next_lo[r] + ADDR_W'(span - 1);
            end
        end
        apply_regions();
    endtask

    // Biased towards the start of a region, its last byte and the end of
    // its store, where the written bytes and the edge cases sit.
    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        int pick;
        r    = $urandom_range(0, REGION_COUNT - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return region_lo[r] + ADDR_W'($urandom_range(0, 23));
        if (pick < 65)
            return region_hi[r] - ADDR_W'($urandom_range(0, 3));
        if (pick < 75)
            return region_lo[r] + ADDR_W'(REGION_BYTES - 2 + $urandom_range(0, 3));
        return ADDR_W'($urandom);
    endfunction

    task automatic random_request();
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] next_addr;
        logic [DATA_W-1:0] data;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            cmd = rmm_pkg::CMD_READ_BYTE;
        else if (pick < 45)
            cmd = rmm_pkg::CMD_WRITE_BYTE;
        else if (pick < 70)
            cmd = rmm_pkg::CMD_READ_WORD;
        else if (pick < 88)
            cmd = rmm_pkg::CMD_WRITE_WORD;
        else if (pick < 95)
            cmd = rmm_pkg::CMD_PROBE;
        else
            cmd = CMD_W'($urandom_range(int'(rmm_pkg::CMD_PROBE) + 1, CMD_TOP));
        addr      = pick_address();
        next_addr = addr + 1'b1;
        data      = DATA_W'($urandom);
        // a read of a byte nobody wrote turns into the matching write
        if (cmd == rmm_pkg::CMD_READ_BYTE && !byte_defined(addr))
            cmd = rmm_pkg::CMD_WRITE_BYTE;
        if (cmd == rmm_pkg::CMD_READ_WORD &&
            !(byte_defined(addr) && byte_defined(next_addr)))
            cmd = rmm_pkg::CMD_WRITE_WORD;
        send_request(cmd, addr, data);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset bounds: every region is [0, 0], so only address 0 is mapped
    // (to region zero). Covers the word wrap at the top of the bus.
    task automatic test_after_reset();
        send_request(rmm_pkg::CMD_WRITE_WORD, 16'hffff, 16'h1234);  // first byte unmapped
        send_request(rmm_pkg::CMD_READ_WORD,  16'hffff, 16'h0000);
        send_request(rmm_pkg::CMD_READ_BYTE,  16'h0000, 16'h0000);
        send_request(rmm_pkg::CMD_READ_WORD,  16'h0000, 16'h0000);  // second byte unmapped
        send_request(rmm_pkg::CMD_PROBE,      16'h0001, 16'hffff);
    endtask

    // Overlap, store overrun, inverted region, word crossing regions
    task automatic test_overlap_and_edges();
        next_lo = '{16'h1000, 16'h1800, 16'h5000, 16'hf800};
        next_hi = '{16'h1fff, 16'h3000, 16'h4000, 16'hffff};
        apply_regions();
        send_request(rmm_pkg::CMD_WRITE_BYTE, 16'h1000, 16'hffa5);  // high byte ignored
        send_request(rmm_pkg::CMD_READ_BYTE,  16'h1000, 16'h0000);
        send_request(rmm_pkg::CMD_WRITE_WORD, 16'h1fff, 16'hbeef);  // low byte in region one
        send_request(rmm_pkg::CMD_READ_WORD,  16'h1fff, 16'h0000);
        send_request(rmm_pkg::CMD_WRITE_WORD, 16'h27ff, 16'h0000);  // second byte past store
        send_request(rmm_pkg::CMD_READ_WORD,  16'h27ff, 16'hffff);
        send_request(rmm_pkg::CMD_PROBE,      16'h2800, 16'h0000);  // no fallback past store
        send_request(rmm_pkg::CMD_PROBE,      16'h3000, 16'h0000);
        send_request(rmm_pkg::CMD_PROBE,      16'h4800, 16'h0000);  // inverted region
        send_request(rmm_pkg::CMD_WRITE_WORD, 16'hffff, 16'hffff);
        send_request(rmm_pkg::CMD_READ_WORD,  16'hffff, 16'h0000);
        send_request(rmm_pkg::CMD_READ_BYTE,  16'h0100, 16'h0000);
        send_request(rmm_pkg::CMD_WRITE_BYTE, 16'h0100, 16'h00ff);  // dropped
        send_request(rmm_pkg::CMD_WRITE_WORD, 16'hf800, 16'h8001);
        send_request(rmm_pkg::CMD_READ_WORD,  16'hf800, 16'h0000);
        send_request(rmm_pkg::CMD_PROBE,      16'h1800, 16'h0000);  // overlap, region zero wins
        for (int c = int'(rmm_pkg::CMD_PROBE) + 1; c <= int'(CMD_TOP); c++)
            send_request(c[CMD_W-1:0], 16'h1000, 16'h5a5a);
        send_request(rmm_pkg::CMD_READ_BYTE,  16'h1000, 16'h0000);  // unused codes left it alone
    endtask

    // Extreme bounds: a full-bus region behind two store-sized ones and an
    // inverted region at the very ends. Sender pauses for a full drain midway.
    task automatic test_full_span_map(input int count);
        next_lo = '{16'hf000, 16'h0000, 16'h0000, 16'hffff};
        next_hi = '{16'hffff, 16'h0fff, 16'hffff, 16'h0000};
        apply_regions();
        for (int i = 0; i < count; i++)
        begin
            random_request();
            if (i == count / 2)
                wait_drained();
        end
    endtask

    task automatic test_random_maps(input int settings, input int count);
        repeat (settings)
        begin
            random_regions();
            repeat (count) random_request();
        end
    endtask

    // Request valid held high throughout
    task automatic test_back_to_back(input int count);
        random_regions();
        sender_steady = 1'b1;
        burst_left    = 0;
        repeat (count) random_request();
        sender_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: stall pattern, checker and watchdog
    // ------------------------------------------------------------------
    stall_mode_t   stall_mode  = STALL_NONE;
    int            mode_left   = 0;
    int            run_left    = 0;
    map_response_t want_rsp;
    int            idle_cycles = 0;

    // Stretches of always-ready, sparse random stalls and long stalls
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:
                rsp_ch.ready = 1'b1;
            STALL_SPARSE:
                rsp_ch.ready = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left <= 0)
                begin
                    rsp_ch.ready = (rsp_ch.ready !== 1'b1);
                    run_left     = rsp_ch.ready ? $urandom_range(1, 4) : $urandom_range(1, 12);
                end
                run_left--;
            end
        endcase
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response with no request outstanding");
                error_count++;
            end
            else
            begin
                want_rsp = pending_responses.pop_front();
                check_field("read_data", want_rsp.read_data, rsp_ch.read_data);
                check_field("mapped", DATA_W'(want_rsp.mapped), DATA_W'(rsp_ch.mapped));
                check_field("region_hit", DATA_W'(want_rsp.region_hit),
                            DATA_W'(rsp_ch.region_hit));
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: no handshake for %0d cycles, %0d responses outstanding",
                     IDLE_LIMIT, pending_responses.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.cmd         = rmm_pkg::CMD_PROBE;
        req_ch.bus_address = '0;
        req_ch.write_data  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        read_count         = 0;
        write_count        = 0;
        probe_count        = 0;
        unmapped_count     = 0;
        setting_count      = 0;
        burst_left         = 0;
        sender_steady      = 1'b0;
        for (int r = 0; r < REGION_COUNT; r++)
        begin
            region_lo[r] = '0;
            region_hi[r] = '0;
        end
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            shadow_bytes[i] = '0;
            byte_written[i] = 1'b0;
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_overlap_and_edges();
        test_full_span_map(300);
        test_random_maps(4, 300);
        test_back_to_back(330);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d requests (%0d reads, %0d writes, %0d probes), %0d unmapped",
                 read_count + write_count + probe_count, read_count, write_count,
                 probe_count, unmapped_count);
        $display("tb: %0d region settings, %0d responses checked, %0d mismatches",
                 setting_count, checked_count, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
